>>> rtl/core/ehqc_pkg.sv
// Shared constants and types of the exponent histogram quantile centre.
package ehqc_pkg;

  localparam int unsigned BINS_DEF        = 64;
  localparam int unsigned MAX_SAMPLES_DEF = 1048576;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = 21;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_RANGE_LOW       = 3'd0;
  localparam logic [IDX_W-1:0] REG_RANGE_HIGH      = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW_QUANTILE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIGH_QUANTILE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FALLBACK_CENTER = 3'd4;
  localparam logic [IDX_W-1:0] REG_FALLBACK_SPREAD = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
    logic [DATA_W-1:0]        low_quantile;
    logic [DATA_W-1:0]        high_quantile;
    logic signed [DATA_W-1:0] fallback_center;
    logic signed [DATA_W-1:0] fallback_spread;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic sample_load;
    logic div_start;
    logic bin_write;
    logic scan_start;
    logic scan_step;
    logic edge_start;
    logic result_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic scan_done;
    logic edge_done;
  } stat_t;

endpackage

>>> rtl/core/ehqc_if.sv
// Valid/ready stream interfaces of the exponent histogram quantile centre.
interface ehqc_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ehqc_pkg::DATA_W-1:0] exponent;
  logic                            last;
  modport source (output valid, output exponent, output last, input ready);
  modport sink   (input valid, input exponent, input last, output ready);
endinterface

interface ehqc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ehqc_pkg::DATA_W-1:0] center;
  logic signed [ehqc_pkg::DATA_W-1:0] spread;
  logic [ehqc_pkg::CNT_W-1:0]         kept_count;
  logic                               empty_res;
  logic                               used_fallback;
  modport source (output valid, output center, output spread, output kept_count,
                  output empty_res, output used_fallback, input ready);
  modport sink   (input valid, input center, input spread, input kept_count,
                  input empty_res, input used_fallback, output ready);
endinterface

>>> rtl/core/ehqc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ehqc_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> rtl/core/ehqc_datapath.sv
// Datapath: binning, histogram memory, cumulative scan and edge arithmetic.
module ehqc_datapath #(
  parameter int unsigned BINS        = ehqc_pkg::BINS_DEF,
  parameter int unsigned MAX_SAMPLES = ehqc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ehqc_pkg::cfg_t                     cfg,
  input  ehqc_pkg::cmd_t                     cmd,
  output ehqc_pkg::stat_t                    stat,
  input  logic signed [ehqc_pkg::DATA_W-1:0] in_exponent,
  output logic signed [ehqc_pkg::DATA_W-1:0] res_center,
  output logic signed [ehqc_pkg::DATA_W-1:0] res_spread,
  output logic [ehqc_pkg::CNT_W-1:0]         res_count,
  output logic                               res_empty,
  output logic                               res_fallback
);
  import ehqc_pkg::*;

  localparam int unsigned NB    = BINS + 1;
  localparam int unsigned AW    = $clog2(NB);
  localparam int unsigned BW    = $clog2(BINS);
  localparam int unsigned RW    = 17;
  localparam int unsigned NUM_W = RW + BW;
  localparam int unsigned PW    = CNT_W + 16;
  localparam int unsigned MAXC  = (MAX_SAMPLES >= (1 << CNT_W)) ?
                                  ((1 << CNT_W) - 1) : MAX_SAMPLES;
  localparam int unsigned EW    = AW + 16;
  localparam int unsigned MW    = EW + 1;
  localparam int unsigned SH    = EW + BW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(BINS) - 64'd1) / 64'(BINS);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [CNT_W-1:0] mem [NB];
  logic [CNT_W-1:0] rd_r;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    clr_r;
  logic             clr_busy_r;
  logic [CNT_W-1:0] kept_r;
  logic             keep_r;
  logic             neg_r;
  logic [AW-1:0]    lo_i_r, hi_i_r;

  logic signed [RW-1:0] r_s, d_s;
  logic signed [RW+BW+1:0] d2b;
  logic                 keep_c;

  assign r_s = RW'(cfg.range_high) - RW'(cfg.range_low);
  assign d_s = RW'(in_exponent) - RW'(cfg.range_low);
  assign d2b = (RW+BW+2)'(d_s) * (RW+BW+2)'(2 * BINS);
  assign keep_c = (r_s > 0) && (d2b >= -(RW+BW+2)'(r_s)) && (d_s <= r_s) &&
                  (kept_r < CNT_W'(MAXC));

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [RW-1:0]    div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // Divide d*BINS by R to find the bin.
  assign div_start = cmd.div_start;
  assign div_num   = NUM_W'(d_s[RW-2:0]) * NUM_W'(BINS);
  assign div_den   = r_s;

  ehqc_div #(.NUM_W(NUM_W), .DEN_W(RW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    addr_nxt = addr_r;
    if (div_done) begin
      if (neg_r) addr_nxt = '0;
      else if (div_quo > NUM_W'(BINS)) addr_nxt = AW'(BINS);
      else addr_nxt = AW'(div_quo);
    end else if (cmd.scan_start) begin
      addr_nxt = '0;
    end else if (cmd.scan_step && addr_r != AW'(BINS)) begin
      addr_nxt = addr_r + 1'b1;
    end
  end

  // Histogram memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (clr_busy_r) mem[clr_r] <= '0;
    else if (cmd.bin_write && keep_r) mem[addr_r] <= rd_r + 1'b1;
    rd_r <= mem[addr_nxt];
  end

  // Scan: rd_r holds bin addr_r during scan_step.
  logic [CNT_W-1:0] cum_r;
  logic [CNT_W-1:0] cum_c;
  logic             have_lo_r, have_hi_r, scan_done_r;
  logic [PW-1:0]    qlo_n, qhi_n, cum_sh;
  logic [PW-1:0]    qlo_r, qhi_r;

  assign cum_c  = cum_r + rd_r;
  assign cum_sh = {cum_c, 16'd0};
  assign qlo_n  = PW'(cfg.low_quantile) * PW'(kept_r);
  assign qhi_n  = PW'(cfg.high_quantile) * PW'(kept_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r   <= 1'b0;
      clr_r        <= '0;
      kept_r       <= '0;
      keep_r       <= 1'b0;
      have_lo_r    <= 1'b0;
      have_hi_r    <= 1'b0;
      scan_done_r  <= 1'b0;
      addr_r       <= '0;
    end else begin
      addr_r      <= addr_nxt;
      scan_done_r <= 1'b0;
      if (cmd.clear_start) begin
        clr_busy_r <= 1'b1;
        clr_r      <= '0;
        kept_r     <= '0;
      end else if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == AW'(BINS)) clr_busy_r <= 1'b0;
      end
      if (cmd.sample_load) begin
        keep_r <= keep_c;
        neg_r  <= d_s < 0;
      end
      if (cmd.bin_write && keep_r) kept_r <= kept_r + 1'b1;
      if (cmd.scan_start) begin
        cum_r     <= '0;
        have_lo_r <= 1'b0;
        have_hi_r <= 1'b0;
        qlo_r     <= qlo_n;
        qhi_r     <= qhi_n;
      end else if (cmd.scan_step && !have_hi_r) begin
        cum_r <= cum_c;
        if (!have_lo_r && cum_sh > qlo_r) begin
          have_lo_r <= 1'b1;
          lo_i_r    <= addr_r;
        end
        if (cum_sh > qhi_r) begin
          have_hi_r <= 1'b1;
          hi_i_r    <= addr_r;
        end
        if (cum_sh > qhi_r || addr_r == AW'(BINS)) scan_done_r <= 1'b1;
      end
    end
  end

  // Edge computation: i*R, then reciprocal multiply by 1/BINS, then add range_low.
  logic [EW-1:0]        lo_n_r, hi_n_r;
  logic [EW+MW-1:0]     lo_p, hi_p;
  logic [15:0]          lo_q_r, hi_q_r;
  logic                 e1_r, e2_r, edge_done_r;
  logic signed [RW:0]   lo_edge_r, hi_edge_r;
  logic signed [RW:0]   sum_c, dif_c;

  assign lo_p  = (EW+MW)'(lo_n_r) * (EW+MW)'(RECIP_C);
  assign hi_p  = (EW+MW)'(hi_n_r) * (EW+MW)'(RECIP_C);
  assign sum_c = lo_edge_r + hi_edge_r;
  assign dif_c = hi_edge_r - lo_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r        <= 1'b0;
      e2_r        <= 1'b0;
      edge_done_r <= 1'b0;
    end else begin
      e1_r        <= cmd.edge_start;
      e2_r        <= e1_r;
      edge_done_r <= e2_r;
      if (cmd.edge_start) begin
        lo_n_r <= EW'(lo_i_r) * EW'(r_s[RW-2:0]);
        hi_n_r <= EW'(hi_i_r) * EW'(r_s[RW-2:0]);
      end
      if (e1_r) begin
        lo_q_r <= lo_p[SH +: 16];
        hi_q_r <= hi_p[SH +: 16];
      end
      if (e2_r) begin
        lo_edge_r <= (RW+1)'(cfg.range_low) + $signed({2'b00, lo_q_r});
        hi_edge_r <= (RW+1)'(cfg.range_low) + $signed({2'b00, hi_q_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_count <= kept_r;
      res_empty <= kept_r == '0;
      if (kept_r != '0 && have_lo_r && have_hi_r && lo_edge_r < hi_edge_r) begin
        res_center   <= DATA_W'(sum_c >>> 1);
        res_spread   <= DATA_W'(dif_c >>> 1);
        res_fallback <= 1'b0;
      end else begin
        res_center   <= cfg.fallback_center;
        res_spread   <= cfg.fallback_spread;
        res_fallback <= 1'b1;
      end
    end
  end

  assign stat.clear_done = !clr_busy_r;
  assign stat.div_done   = div_done;
  assign stat.scan_done  = scan_done_r;
  assign stat.edge_done  = edge_done_r;
endmodule

>>> rtl/core/ehqc_ctrl.sv
// Controller: sequences histogram clearing, sample binning, scan, edge computation and result hand-off.
module ehqc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output ehqc_pkg::cmd_t  cmd,
  input  ehqc_pkg::stat_t stat
);
  import ehqc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_CLEAR_WAIT, S_IDLE, S_DIV, S_WRITE, S_SCAN0, S_SCAN,
    S_EDGE, S_EDGE_WAIT, S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_start = 1'b1;
        state_nxt = S_CLEAR_WAIT;
      end
      S_CLEAR_WAIT: if (stat.clear_done) state_nxt = S_IDLE;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.sample_load = 1'b1;
          cmd.div_start   = 1'b1;
          last_nxt        = in_last;
          state_nxt       = S_DIV;
        end
      end
      S_DIV: if (stat.div_done) state_nxt = S_WRITE;
      S_WRITE: begin
        cmd.bin_write = 1'b1;
        state_nxt = last_r ? S_SCAN0 : S_IDLE;
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_EDGE;
      end
      S_EDGE: begin
        cmd.edge_start = 1'b1;
        state_nxt = S_EDGE_WAIT;
      end
      S_EDGE_WAIT: if (stat.edge_done) state_nxt = S_RESULT;
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> rtl/core/exponent_histogram_quantile_center_top.sv
// Top level of the exponent histogram quantile centre.
// Bins signed Q4.12 samples into BINS+1 bins and, after a sample marked last, scans the
// cumulative histogram for the low and high quantile bins and reports their centre and
// half-spread. Each sample goes through a serial divider that finds its bin, then one
// read-modify-write of the histogram memory; no new sample is taken meanwhile. A last
// sample adds a scan of up to BINS+1 bins, one bin a cycle, the edge arithmetic and a
// clearing pass over all BINS+1 bins, during which no sample is taken. The same clearing
// pass runs after reset. The result stays in an output register while the next data set
// bins.
module exponent_histogram_quantile_center_top #(
  parameter int unsigned BINS        = ehqc_pkg::BINS_DEF,
  parameter int unsigned MAX_SAMPLES = ehqc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ehqc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ehqc_pkg::DATA_W-1:0]  cfg_wdata,
  ehqc_in_if.sink                      in_if,
  ehqc_out_if.source                   out_if
);
  import ehqc_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_low       <= 16'sd0;
      cfg_r.range_high      <= 16'sd8192;
      cfg_r.low_quantile    <= 16'd3277;
      cfg_r.high_quantile   <= 16'd62259;
      cfg_r.fallback_center <= 16'sd0;
      cfg_r.fallback_spread <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:       cfg_r.range_low       <= cfg_wdata;
        REG_RANGE_HIGH:      cfg_r.range_high      <= cfg_wdata;
        REG_LOW_QUANTILE:    cfg_r.low_quantile    <= cfg_wdata;
        REG_HIGH_QUANTILE:   cfg_r.high_quantile   <= cfg_wdata;
        REG_FALLBACK_CENTER: cfg_r.fallback_center <= cfg_wdata;
        REG_FALLBACK_SPREAD: cfg_r.fallback_spread <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ehqc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_last(in_if.last),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .cmd(cmd), .stat(stat)
  );

  ehqc_datapath #(.BINS(BINS), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .stat(stat),
    .in_exponent(in_if.exponent),
    .res_center(out_if.center), .res_spread(out_if.spread),
    .res_count(out_if.kept_count), .res_empty(out_if.empty_res),
    .res_fallback(out_if.used_fallback)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_start |=> !in_if.ready) else $error("sample taken during clear");
  a_result_fallback_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) && out_if.empty_res |-> out_if.used_fallback)
    else $error("empty result without fallback");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> (out_if.empty_res == (out_if.kept_count == '0)))
    else $error("empty flag disagrees with count");
endmodule
